/* hw/rtl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants and the arctangent table generator for the distance pipe
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int CORDIC_STEPS_DEF = 32;
  localparam int SQRT_STEPS       = 32;

  // 2^62 / 3.6e9, degree*1e7 to fraction of a turn
  localparam logic [30:0]        TURN_K     = 31'd1281023894;
  // cordic gain compensation in q60
  localparam logic signed [63:0] KINV_Q60   = 64'sd700114967507363197;
  localparam logic [63:0]        INV2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0]        PI_Q62     = 64'hC90FDAA22168C235;
  localparam logic [22:0]        RADIUS_RST = 23'd6378137;

  // atan(2^-idx) in 2^-62 turn, taylor sum in q64 scaled by 1/(2 pi)
  function automatic logic [63:0] atan_entry(input int idx);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [63:0]  one_sh;
    logic [127:0] prod;
    logic [63:0]  res;
    int           e;
    int           dnm;
    logic         done;
    acc    = '0;
    term   = '0;
    one_sh = '0;
    done   = 1'b0;
    e      = 0;
    dnm    = 1;
    if (idx == 0) begin
      res = 64'd1 << 59;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = idx * (2 * k + 1);
        if (e > 63) begin
          done = 1'b1;
        end
        if (!done) begin
          dnm    = 2 * k + 1;
          one_sh = 64'd1 << (64 - e);
          term   = one_sh / 64'(dnm);
          if (k[0]) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
      prod = 128'(acc) * 128'(INV2PI_Q64);
      res  = (prod[127:64] + 64'd2) >> 2;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/gcd_rot.sv */
// ----------------------------------------------------------------------------
// gcd_rot
// pipelined rotation cordic, one stage per step, sine and cosine in q30
// ----------------------------------------------------------------------------
module gcd_rot #(
  parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [31:0]        turn,
  output logic               out_vld,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import gcd_pkg::*;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  logic               vld_r [STEPS+1];
  logic signed [63:0] x_r   [STEPS+1];
  logic signed [63:0] y_r   [STEPS+1];
  logic signed [63:0] z_r   [STEPS+1];
  quad_t              q_r   [STEPS+1];

  logic [31:0]        u;
  logic signed [30:0] res_ang;
  logic signed [63:0] z0;

  // residual in [-45, 45) degrees plus quadrant
  assign u       = turn + 32'h2000_0000;
  assign res_ang = $signed({1'b0, u[29:0]}) - 31'sh2000_0000;
  assign z0      = {{3{res_ang[30]}}, res_ang, 30'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= KINV_Q60;
    y_r[0] <= '0;
    z_r[0] <= z0;
    q_r[0] <= quad_t'(u[31:30]);
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [63:0] ANG = atan_entry(i);
    logic signed [63:0] x_nxt;
    logic signed [63:0] y_nxt;
    logic signed [63:0] z_nxt;

    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ANG;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1] <= x_nxt;
      y_r[i+1] <= y_nxt;
      z_r[i+1] <= z_nxt;
      q_r[i+1] <= q_r[i];
    end
  end

  logic signed [63:0] x_sum;
  logic signed [63:0] y_sum;
  logic signed [31:0] c_q;
  logic signed [31:0] s_q;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_nxt;
  logic               out_vld_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  // round to q30
  assign x_sum = x_r[STEPS] + 64'sd536870912;
  assign y_sum = y_r[STEPS] + 64'sd536870912;
  assign c_q   = x_sum[61:30];
  assign s_q   = y_sum[61:30];

  always_comb begin
    case (q_r[STEPS])
      QUAD_0: begin
        cos_nxt = c_q;
        sin_nxt = s_q;
      end
      QUAD_1: begin
        cos_nxt = -s_q;
        sin_nxt = c_q;
      end
      QUAD_2: begin
        cos_nxt = -c_q;
        sin_nxt = -s_q;
      end
      default: begin
        cos_nxt = s_q;
        sin_nxt = -c_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign out_vld = out_vld_r;
  assign cos_o   = cos_r;
  assign sin_o   = sin_r;

endmodule

/* hw/rtl/gcd_sqrt.sv */
// ----------------------------------------------------------------------------
// gcd_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module gcd_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [60:0] n,
  output logic        out_vld,
  output logic [30:0] root
);
  import gcd_pkg::*;

  logic        vld_r [SQRT_STEPS+1];
  logic [63:0] n_r   [SQRT_STEPS+1];
  logic [63:0] res_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    n_r[0]   <= 64'(n);
    res_r[0] <= '0;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic [63:0] n_nxt;
    logic [63:0] res_nxt;

    assign trial = res_r[j] + BIT;

    always_comb begin
      if (n_r[j] >= trial) begin
        n_nxt   = n_r[j] - trial;
        res_nxt = (res_r[j] >> 1) + BIT;
      end else begin
        n_nxt   = n_r[j];
        res_nxt = res_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      n_r[j+1]   <= n_nxt;
      res_r[j+1] <= res_nxt;
    end
  end

  assign out_vld = vld_r[SQRT_STEPS];
  assign root    = res_r[SQRT_STEPS][30:0];

endmodule

/* hw/rtl/gcd_vec.sv */
// ----------------------------------------------------------------------------
// gcd_vec
// pipelined vectoring cordic, angle of (x, y) in 2^-62 turn
// ----------------------------------------------------------------------------
module gcd_vec #(
  parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  output logic               out_vld,
  output logic signed [63:0] z_o
);
  import gcd_pkg::*;

  logic               vld_r [STEPS+1];
  logic signed [63:0] x_r   [STEPS+1];
  logic signed [63:0] y_r   [STEPS+1];
  logic signed [63:0] z_r   [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x_in;
    y_r[0] <= y_in;
    z_r[0] <= '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [63:0] ANG = atan_entry(i);
    logic signed [63:0] x_nxt;
    logic signed [63:0] y_nxt;
    logic signed [63:0] z_nxt;

    always_comb begin
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ANG;
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1] <= x_nxt;
      y_r[i+1] <= y_nxt;
      z_r[i+1] <= z_nxt;
    end
  end

  assign out_vld = vld_r[STEPS];
  assign z_o     = z_r[STEPS];

endmodule

/* hw/rtl/great_circle_distance_top.sv */
// ----------------------------------------------------------------------------
// great_circle_distance_top
// haversine distance between two points, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   request channel: drive the four coordinates (1e-7 degree, signed) and
//   raise start; the request is taken at an edge where start is high and
//   busy is low. busy is high during reset and drops at the first edge
//   after it, so from then on a request can be taken on every cycle.
//   result channel: out_valid is high for exactly one cycle with
//   out_distance_mm; results leave in request order. the receiver cannot
//   stall, and nothing inside waits on it.
//   a request passes the input register, the angle conversion, the rotation
//   cordic pipe, the haversine stages, the 32-stage square root pipe, the
//   vectoring cordic pipe and the millimetre scaling (cordic pipes: one
//   stage per step). throughput: one request per cycle.
//   config: cfg_earth_radius_m is written when cfg_valid and cfg_ready are
//   both high; write it only with no request in flight. reset loads
//   6378137 m.
//   reset: synchronous, active low; clears all valid bits, reloads the
//   radius, and holds busy high while asserted.
// ----------------------------------------------------------------------------
module great_circle_distance_top #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_lon,
  input  logic signed [30:0] in_first_lat,
  input  logic signed [31:0] in_second_lon,
  input  logic signed [30:0] in_second_lat,
  // result
  output logic               out_valid,
  output logic [34:0]        out_distance_mm,
  // radius register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [22:0]        cfg_earth_radius_m
);
  import gcd_pkg::*;

  // ---------------- control and radius ----------------
  logic        busy_r;
  logic [22:0] radius_r;
  logic [32:0] m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      radius_r <= RADIUS_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_earth_radius_m;
      end
    end
  end

  // radius in mm, follows the register in the next cycle
  always_ff @(posedge clk) begin
    m_r <= 33'(radius_r) * 33'd1000;
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // ---------------- input register ----------------
  logic               v0_r;
  logic signed [31:0] lon1_r;
  logic signed [30:0] lat1_r;
  logic signed [31:0] lon2_r;
  logic signed [30:0] lat2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    lon1_r <= in_first_lon;
    lat1_r <= in_first_lat;
    lon2_r <= in_second_lon;
    lat2_r <= in_second_lat;
  end

  // ---------------- angle conversion, four lanes ----------------
  // lanes: lat1, lat2, half latitude diff, half longitude diff
  logic signed [32:0] val   [4];
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic [32:0]        mag_r [4];
  logic               sgn_r [4];
  logic               sgn2_r[4];
  logic [63:0]        prod_r[4];
  logic [31:0]        turn_r[4];

  assign val[0] = {{2{lat1_r[30]}}, lat1_r};
  assign val[1] = {{2{lat2_r[30]}}, lat2_r};
  assign val[2] = {{2{lat1_r[30]}}, lat1_r} - {{2{lat2_r[30]}}, lat2_r};
  assign val[3] = {lon1_r[31], lon1_r} - {lon2_r[31], lon2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    // coordinates scale by 2^-30, half differences by 2^-31
    localparam int SH = (k < 2) ? 30 : 31;
    logic [64:0] rsum;
    logic [64:0] rshift;

    assign rsum   = {1'b0, prod_r[k]} + (65'd1 << (SH - 1));
    assign rshift = rsum >> SH;

    always_ff @(posedge clk) begin
      mag_r[k]  <= val[k][32] ? 33'(-val[k]) : 33'(val[k]);
      sgn_r[k]  <= val[k][32];
      prod_r[k] <= 64'(mag_r[k]) * 64'(TURN_K);
      sgn2_r[k] <= sgn_r[k];
      turn_r[k] <= sgn2_r[k] ? -rshift[31:0] : rshift[31:0];
    end
  end

  // ---------------- sine and cosine ----------------
  logic               rv_lat1;
  logic               rv_lat2;
  logic               rv_dlat;
  logic               rv_dlon;
  logic signed [31:0] c1;
  logic signed [31:0] c2;
  logic signed [31:0] sd;
  logic signed [31:0] so;

  gcd_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .turn(turn_r[0]),
    .out_vld(rv_lat1), .cos_o(c1), .sin_o()
  );

  gcd_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .turn(turn_r[1]),
    .out_vld(rv_lat2), .cos_o(c2), .sin_o()
  );

  gcd_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .turn(turn_r[2]),
    .out_vld(rv_dlat), .cos_o(), .sin_o(sd)
  );

  gcd_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .turn(turn_r[3]),
    .out_vld(rv_dlon), .cos_o(), .sin_o(so)
  );

  // ---------------- haversine term h in q60 ----------------
  logic               vh1_r, vh2_r, vh3_r, vh4_r, vh5_r, vh6_r, vh7_r;
  logic signed [63:0] gfull_r;
  logic signed [63:0] sdsq_r, sdsq2_r, sdsq3_r, sdsq4_r, sdsq5_r;
  logic signed [31:0] so1_r, so2_r, so3_r, so4_r;
  logic signed [63:0] gsum;
  logic signed [33:0] g_r;
  logic signed [65:0] tp_r;
  logic signed [65:0] tsum;
  logic signed [35:0] t_r;
  logic signed [67:0] ts_r;
  logic signed [68:0] hsum;
  logic [60:0]        h_nxt;
  logic [60:0]        h_r;
  logic [60:0]        hh_r;
  logic [60:0]        hc_r;

  assign gsum = gfull_r + 64'sd536870912;
  assign tsum = tp_r + 66'sd536870912;
  assign hsum = {{5{sdsq5_r[63]}}, sdsq5_r} + {ts_r[67], ts_r};

  // clamp to [0, 1]
  always_comb begin
    if (hsum < 0) begin
      h_nxt = '0;
    end else if (hsum > 69'sd1152921504606846976) begin
      h_nxt = 61'd1 << 60;
    end else begin
      h_nxt = hsum[60:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh1_r <= 1'b0;
      vh2_r <= 1'b0;
      vh3_r <= 1'b0;
      vh4_r <= 1'b0;
      vh5_r <= 1'b0;
      vh6_r <= 1'b0;
      vh7_r <= 1'b0;
    end else begin
      vh1_r <= rv_lat1 && rv_lat2 && rv_dlat && rv_dlon;
      vh2_r <= vh1_r;
      vh3_r <= vh2_r;
      vh4_r <= vh3_r;
      vh5_r <= vh4_r;
      vh6_r <= vh5_r;
      vh7_r <= vh6_r;
    end
  end

  always_ff @(posedge clk) begin
    gfull_r <= c1 * c2;
    sdsq_r  <= sd * sd;
    so1_r   <= so;
    g_r     <= gsum[63:30];
    sdsq2_r <= sdsq_r;
    so2_r   <= so1_r;
    tp_r    <= g_r * so2_r;
    sdsq3_r <= sdsq2_r;
    so3_r   <= so2_r;
    t_r     <= tsum[65:30];
    sdsq4_r <= sdsq3_r;
    so4_r   <= so3_r;
    ts_r    <= t_r * so4_r;
    sdsq5_r <= sdsq4_r;
    h_r     <= h_nxt;
    hh_r    <= h_r;
    hc_r    <= (61'd1 << 60) - h_r;
  end

  // ---------------- square roots and arcsine ----------------
  logic        sv_h;
  logic        sv_c;
  logic [30:0] hs_root;
  logic [30:0] hc_root;
  logic        zv;
  logic signed [63:0] z;

  gcd_sqrt u_sqrt_h (
    .clk(clk), .rst_n(rst_n), .in_vld(vh7_r), .n(hh_r),
    .out_vld(sv_h), .root(hs_root)
  );

  gcd_sqrt u_sqrt_c (
    .clk(clk), .rst_n(rst_n), .in_vld(vh7_r), .n(hc_r),
    .out_vld(sv_c), .root(hc_root)
  );

  // asin(sqrt h) as atan2(sqrt h, sqrt(1 - h)), both in q60
  gcd_vec #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk(clk), .rst_n(rst_n), .in_vld(sv_h && sv_c),
    .x_in({3'b000, hc_root, 30'd0}), .y_in({3'b000, hs_root, 30'd0}),
    .out_vld(zv), .z_o(z)
  );

  // ---------------- scale to millimetres ----------------
  logic         vz_r, vm1_r, vm2_r, vm3_r, vn1_r, out_valid_r;
  logic [62:0]  zc_r;
  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [63:0]  pp00b_r, pp11b_r;
  logic [64:0]  mid_r;
  logic [127:0] full;
  logic [63:0]  p_r;
  logic [64:0]  a0_r;
  logic [64:0]  a1_r;
  logic [97:0]  dsum;
  logic [34:0]  dist_r;

  // p = z * pi / 2^64 from four 32-bit partial products
  assign full = {pp11b_r, pp00b_r} + {31'd0, mid_r, 32'd0};
  // (p * radius_mm + 2^57) / 2^58
  assign dsum = {1'b0, a1_r, 32'd0} + {33'd0, a0_r} + (98'd1 << 57);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vz_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      vm3_r       <= 1'b0;
      vn1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vz_r        <= zv;
      vm1_r       <= vz_r;
      vm2_r       <= vm1_r;
      vm3_r       <= vm2_r;
      vn1_r       <= vm3_r;
      out_valid_r <= vn1_r;
    end
  end

  always_ff @(posedge clk) begin
    zc_r    <= z[63] ? 63'd0 : z[62:0];
    pp00_r  <= 64'(zc_r[31:0]) * 64'(PI_Q62[31:0]);
    pp01_r  <= 64'(zc_r[31:0]) * 64'(PI_Q62[63:32]);
    pp10_r  <= 64'(zc_r[62:32]) * 64'(PI_Q62[31:0]);
    pp11_r  <= 64'(zc_r[62:32]) * 64'(PI_Q62[63:32]);
    mid_r   <= 65'(pp01_r) + 65'(pp10_r);
    pp00b_r <= pp00_r;
    pp11b_r <= pp11_r;
    p_r     <= full[127:64];
    a0_r    <= 65'(p_r[31:0]) * 65'(m_r);
    a1_r    <= 65'(p_r[63:32]) * 65'(m_r);
    dist_r  <= dsum[92:58];
  end

  assign out_valid       = out_valid_r;
  assign out_distance_mm = dist_r;

endmodule

/* hw/rtl/gcd_chk.sv */
// ----------------------------------------------------------------------------
// gcd_chk
// port level checks for the distance pipe, bound to the top level
// ----------------------------------------------------------------------------
module gcd_chk #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [34:0] out_distance_mm
);
  localparam int LAT = 2 * CORDIC_STEPS + 53;

  // reset flushes every request in flight
  a_rst_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // every accepted request gives one result after the fixed latency
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after request");

  // no result without a request
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a request");

  // half a circumference of the largest radius bounds the distance
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_mm <= 35'd27000000000))
    else $error("distance out of range");

endmodule

bind great_circle_distance_top gcd_chk #(.CORDIC_STEPS(CORDIC_STEPS)) u_gcd_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_distance_mm(out_distance_mm)
);

/* tb/tb_great_circle_distance_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance_top
// self-checking bench for the haversine distance pipe: a directed table of
// extreme and special point pairs, then bursts of random pairs under several
// radius settings, every result checked against a bit-exact local model
// ----------------------------------------------------------------------------
module tb_great_circle_distance_top;

  localparam int       STEPS    = gcd_pkg::CORDIC_STEPS_DEF;
  localparam int       LATENCY  = 2 * STEPS + 53;
  localparam longint   NO_VALUE = -1;
  localparam int       N_RANDOM = 630;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_first_lon;
  logic signed [30:0] in_first_lat;
  logic signed [31:0] in_second_lon;
  logic signed [30:0] in_second_lat;
  logic               out_valid;
  logic [34:0]        out_distance_mm;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [22:0]        cfg_earth_radius_m;

  // local copy of the radius register and the arctangent table
  logic [22:0]        radius_m;
  longint             atan_turn [STEPS];
  // distances still owed by the pipe, oldest first
  logic [34:0]        distance_fifo [$];
  int                 n_errors;

  great_circle_distance_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_first_lon       (in_first_lon),
    .in_first_lat       (in_first_lat),
    .in_second_lon      (in_second_lon),
    .in_second_lat      (in_second_lat),
    .out_valid          (out_valid),
    .out_distance_mm    (out_distance_mm),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_earth_radius_m (cfg_earth_radius_m)
  );

  // 4 ns clock
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // --------------------------------------------------------------------------
  // distance model
  // --------------------------------------------------------------------------

  // atan(2^-i) in 2^-62 turn, from a truncated taylor series in q64
  function automatic void fill_atan_table();
    longint unsigned sum;
    longint unsigned term;
    logic [127:0]    prod;
    int              ex;
    atan_turn[0] = longint'(64'd1 << 59);
    for (int i = 1; i < STEPS; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        ex = i * (2 * k + 1);
        if (ex > 63) break;
        term = (64'd1 << (64 - ex)) / longint'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      prod = {64'd0, sum} * {64'd0, gcd_pkg::INV2PI_Q64};
      atan_turn[i] = longint'((prod[127:64] + 64'd2) >> 2);
    end
  endfunction

  // degree*1e7 (or a doubled half difference) to a fraction of a turn
  function automatic logic [31:0] deg_to_turn(longint v, int sh);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : v;
    q   = (mag * 64'(gcd_pkg::TURN_K) + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic longint round_to_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // rotation cordic on the residual angle, then quadrant fix-up
  function automatic void turn_sin_cos(logic [31:0] ang, output longint c_o,
                                       output longint s_o);
    logic [31:0] u;
    longint      x, y, z, dx, dy, c, s;
    u = ang + (32'd1 << 29);
    z = (longint'({2'b00, u[29:0]}) - (64'sd1 <<< 29)) * (64'sd1 <<< 30);
    x = gcd_pkg::KINV_Q60;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_turn[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_turn[i];
      end
    end
    c = round_to_q30(x);
    s = round_to_q30(y);
    case (u[31:30])
      2'd0: begin c_o = c;  s_o = s;  end
      2'd1: begin c_o = -s; s_o = c;  end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [34:0] haversine_mm(logic signed [31:0] lon1,
                                               logic signed [30:0] lat1,
                                               logic signed [31:0] lon2,
                                               logic signed [30:0] lat2,
                                               logic [22:0] radius);
    longint          c1, s1, c2, s2, cd, sd, co, so, g, t, h, x, y, z, dx, dy;
    longint unsigned hs, hc, scale;
    logic [127:0]    prod;
    logic [63:0]     angle_q58;
    turn_sin_cos(deg_to_turn(longint'(lat1), 30), c1, s1);
    turn_sin_cos(deg_to_turn(longint'(lat2), 30), c2, s2);
    turn_sin_cos(deg_to_turn(longint'(lat1) - longint'(lat2), 31), cd, sd);
    turn_sin_cos(deg_to_turn(longint'(lon1) - longint'(lon2), 31), co, so);
    g = round_to_q30(c1 * c2);
    t = round_to_q30(g * so);
    h = sd * sd + t * so;
    if (h < 0) h = 0;
    if (h > (64'sd1 <<< 60)) h = 64'sd1 <<< 60;
    hs = floor_sqrt(h);
    hc = floor_sqrt((64'd1 << 60) - h);
    // vectoring cordic gives the half central angle
    x = longint'(hc) * (64'sd1 <<< 30);
    y = longint'(hs) * (64'sd1 <<< 30);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_turn[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_turn[i];
      end
    end
    if (z < 0) z = 0;
    prod      = {64'd0, z} * {64'd0, gcd_pkg::PI_Q62};
    angle_q58 = prod[127:64];
    scale     = 64'(radius) * 64'd1000;
    prod      = {64'd0, angle_q58} * {64'd0, scale};
    prod      = (prod + (128'd1 << 57)) >> 58;
    return prod[34:0];
  endfunction

  // --------------------------------------------------------------------------
  // request and radius drivers
  // --------------------------------------------------------------------------

  // one request; returns at the accepting edge with start still high
  task automatic send_request(logic signed [31:0] lon1, logic signed [30:0] lat1,
                              logic signed [31:0] lon2, logic signed [30:0] lat2);
    start         <= 1'b1;
    in_first_lon  <= lon1;
    in_first_lat  <= lat1;
    in_second_lon <= lon2;
    in_second_lat <= lat2;
    do @(posedge clk); while (busy);
    distance_fifo = {distance_fifo, haversine_mm(lon1, lat1, lon2, lat2, radius_m)};
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every owed distance, then a few spare cycles
  task automatic drain_pipe();
    idle_cycles(1);
    while (distance_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_radius(logic [22:0] r);
    cfg_valid          <= 1'b1;
    cfg_earth_radius_m <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_m = r;
  endtask

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  typedef struct {
    logic signed [31:0] lon1;
    logic signed [30:0] lat1;
    logic signed [31:0] lon2;
    logic signed [30:0] lat2;
    logic [22:0]        radius;
    longint             known_mm; // NO_VALUE: take the model's value
  } point_pair_t;

  localparam logic signed [31:0] LON_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] LON_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [30:0] LAT_MIN = 31'sh4000_0000;
  localparam logic signed [30:0] LAT_MAX = 31'sh3FFF_FFFF;

  point_pair_t pair_table [21] = '{
    // reset radius
    '{0, 0, 0, 0, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{123456789, 456789012, 123456789, 456789012, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{0, 0, 1800000000, 0, gcd_pkg::RADIUS_RST, NO_VALUE},          // antipodal
    '{0, 900000000, 0, -900000000, gcd_pkg::RADIUS_RST, NO_VALUE},  // pole to pole
    '{-1800000000, 0, 1800000000, 0, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{0, 900000000, 1234567, 900000000, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{1, 0, 0, 0, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{0, 1, 0, -1, gcd_pkg::RADIUS_RST, NO_VALUE},
    // latitude beyond the pole, longitude beyond the date line
    '{0, LAT_MAX, 0, LAT_MIN, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{LON_MAX, 0, LON_MIN, 0, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{LON_MIN, LAT_MIN, LON_MAX, LAT_MAX, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{2000000000, 450000000, -2000000000, -450000000, gcd_pkg::RADIUS_RST, NO_VALUE},
    '{-1, -1, 0, 0, gcd_pkg::RADIUS_RST, NO_VALUE},
    // radius extremes of the legal range
    '{0, 0, 1800000000, 0, 23'd6000000, NO_VALUE},
    '{0, 900000000, 0, -900000000, 23'd7000000, NO_VALUE},
    '{LON_MAX, LAT_MAX, LON_MIN, LAT_MIN, 23'd7000000, NO_VALUE},
    // full-scale radius
    '{0, 0, 1800000000, 0, 23'h7FFFFF, NO_VALUE},
    '{LON_MIN, LAT_MAX, LON_MAX, LAT_MIN, 23'h7FFFFF, NO_VALUE},
    // zero radius collapses every distance
    '{0, 0, 1800000000, 0, 23'd0, 0},
    '{LON_MIN, LAT_MIN, LON_MAX, LAT_MAX, 23'd0, 0},
    '{-123456789, 555555555, 987654321, -333333333, 23'd0, 0}
  };

  // random coordinate: mostly legal, sometimes any 32/31-bit value
  function automatic logic signed [31:0] rand_lon(bit wild);
    if (wild) return $urandom;
    return 32'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
  endfunction

  function automatic logic signed [30:0] rand_lat(bit wild);
    if (wild) return 31'($urandom);
    return 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every strobe must match the oldest owed distance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (distance_fifo.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d",
                 $time, out_distance_mm);
        n_errors++;
      end else begin
        if (out_distance_mm !== distance_fifo[0]) begin
          $display("%0t distance_mm mismatch: expected %0d, actual %0d",
                   $time, distance_fifo[0], out_distance_mm);
          n_errors++;
        end
        void'(distance_fifo.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [22:0]        radius_plan [5];
    logic signed [31:0] lon1, lon2;
    logic signed [30:0] lat1, lat2;
    int                 burst;
    int                 per_phase;
    bit                 wild;
    bit                 calm;

    n_errors           = 0;
    rst_n              = 1'b0;
    start              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_earth_radius_m = '0;
    in_first_lon       = '0;
    in_first_lat       = '0;
    in_second_lon      = '0;
    in_second_lat      = '0;
    radius_m           = gcd_pkg::RADIUS_RST;
    fill_atan_table();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; the radius changes only with the pipe empty
    foreach (pair_table[i]) begin
      if (pair_table[i].radius != radius_m) begin
        drain_pipe();
        write_radius(pair_table[i].radius);
      end
      send_request(pair_table[i].lon1, pair_table[i].lat1,
                   pair_table[i].lon2, pair_table[i].lat2);
      // the hand-typed value must agree with what was queued
      if (pair_table[i].known_mm != NO_VALUE &&
          distance_fifo[$] != 35'(pair_table[i].known_mm)) begin
        $display("%0t table row %0d: expected %0d, actual model %0d", $time, i,
                 pair_table[i].known_mm, distance_fifo[$]);
        n_errors++;
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end

    // random phases, each under its own radius
    radius_plan[0] = 23'd6000000;
    radius_plan[1] = 23'($urandom_range(6000000, 7000000));
    radius_plan[2] = 23'd7000000;
    radius_plan[3] = 23'($urandom);
    radius_plan[4] = gcd_pkg::RADIUS_RST;
    per_phase = N_RANDOM / 5;
    foreach (radius_plan[p]) begin
      drain_pipe();
      write_radius(radius_plan[p]);
      // some phases run back to back with no gaps at all
      calm  = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(1, 12);
      for (int n = 0; n < per_phase; n++) begin
        wild = ($urandom_range(0, 9) == 0);
        lon1 = rand_lon(wild);
        lat1 = rand_lat(wild);
        case ($urandom_range(0, 3))
          0: begin // close neighbors
            lon2 = lon1 + 32'($urandom_range(0, 2000000)) - 32'sd1000000;
            lat2 = lat1 + 31'($urandom_range(0, 2000000)) - 31'sd1000000;
          end
          1: begin // near antipode
            lon2 = lon1 + 32'sd1800000000 + 32'($urandom_range(0, 20000));
            lat2 = -lat1 + 31'($urandom_range(0, 20000));
          end
          default: begin
            lon2 = rand_lon(wild);
            lat2 = rand_lat(wild);
          end
        endcase
        send_request(lon1, lat1, lon2, lat2);
        if (!calm) begin
          burst--;
          if (burst == 0) begin
            idle_cycles($urandom_range(1, 9));
            burst = $urandom_range(1, 12);
          end
        end
      end
    end

    drain_pipe();
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && distance_fifo.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
